@@ hdl/sha256_pkg.sv @@
// SHA-256 hasher shared types, constants and the rotate helper used by the round functions.
package sha256_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       finish;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_beat_t;

  // Block handed from the packer to the compression engine.
  typedef struct packed {
    logic [511:0] block;
    logic         final_blk;
  } blk_t;

  localparam logic [255:0] IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int unsigned LEN_POS = 56;

  localparam logic [31:0] RK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

endpackage

@@ hdl/sha256_packer.sv @@
// Front end: packs bytes into 512-bit blocks and generates padding.
module sha256_packer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  sha256_pkg::in_beat_t in_data,
  output logic                 in_full,
  output logic                 blk_valid,
  output sha256_pkg::blk_t     blk_data,
  input  logic                 blk_ready
);

  typedef enum logic [1:0] {S_LOAD, S_PAD, S_LEN} state_t;

  state_t       state_r;
  logic [511:0] buf_r;
  logic [5:0]   fill_r;
  logic [60:0]  cnt_r;
  logic         fin_r;
  logic         blk_valid_r;
  logic         blk_final_r;
  logic [511:0] blk_r;
  logic         slot_free;
  logic         acc;

  assign slot_free = !blk_valid_r || blk_ready;
  assign in_full   = (state_r != S_LOAD) || !slot_free;
  assign acc       = in_push && !in_full;
  assign blk_valid = blk_valid_r;
  assign blk_data  = '{block: blk_r, final_blk: blk_final_r};

  // Byte n lives at bits [511-8n -: 8].
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      fill_r      <= '0;
      cnt_r       <= '0;
      fin_r       <= 1'b0;
      blk_valid_r <= 1'b0;
    end else begin
      logic ship;
      ship = 1'b0;
      unique case (state_r)
        S_LOAD: begin
          if (acc) begin
            logic [511:0] b;
            logic [5:0]   f;
            logic         wrap;
            b    = buf_r;
            f    = fill_r;
            wrap = 1'b0;
            if (in_data.has_byte) begin
              b[511 - 8*f -: 8] = in_data.data_byte;
              wrap = (f == 6'd63);
              f    = f + 6'd1;
              cnt_r <= cnt_r + 61'd1;
            end
            if (wrap) begin
              blk_r       <= b;
              blk_final_r <= 1'b0;
              ship        = 1'b1;
            end
            if (in_data.finish) begin
              if (wrap) begin
                // padding goes into a fresh block next
                state_r <= S_PAD;
                buf_r   <= b;
                fill_r  <= f;
              end else begin
                b[511 - 8*f -: 8] = sha256_pkg::PAD_BYTE;
                for (int i = 0; i < 64; i++)
                  if (i > f) b[511 - 8*i -: 8] = 8'h00;
                buf_r  <= b;
                fill_r <= f;
                state_r <= (f >= 6'(sha256_pkg::LEN_POS)) ? S_PAD : S_LEN;
                fin_r  <= (f >= 6'(sha256_pkg::LEN_POS));
              end
            end else begin
              buf_r  <= b;
              fill_r <= f;
            end
          end
        end
        S_PAD: begin
          // fin_r set: buffer already padded, ship it; else 0x80 at byte 0.
          if (slot_free) begin
            if (fin_r) begin
              blk_r       <= buf_r;
              blk_final_r <= 1'b0;
              ship        = 1'b1;
              buf_r       <= '0;
            end else begin
              buf_r <= {sha256_pkg::PAD_BYTE, 504'd0};
            end
            fin_r   <= 1'b0;
            state_r <= S_LEN;
          end
        end
        S_LEN: begin
          if (slot_free) begin
            blk_r       <= {buf_r[511:64], cnt_r, 3'b000};
            blk_final_r <= 1'b1;
            ship        = 1'b1;
            fill_r      <= '0;
            cnt_r       <= '0;
            state_r     <= S_LOAD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
      if (ship) blk_valid_r <= 1'b1;
      else if (blk_ready) blk_valid_r <= 1'b0;
    end
  end

endmodule

@@ hdl/sha256_core.sv @@
// Back end: 64-round compression, one round a cycle, and digest word output.
module sha256_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  blk_valid,
  input  sha256_pkg::blk_t      blk_data,
  output logic                  blk_ready,
  output logic                  out_empty,
  input  logic                  out_pop,
  output sha256_pkg::out_beat_t out_data
);

  typedef enum logic [1:0] {C_IDLE, C_RUN, C_SUM, C_OUT} state_t;

  state_t       state_r;
  logic [255:0] h_r;
  logic [31:0]  v_r [8];
  logic [31:0]  w_r [16];
  logic [5:0]   rnd_r;
  logic [2:0]   idx_r;
  logic         fin_r;
  logic [31:0]  t1, t2, wn, s0, s1;

  assign blk_ready = (state_r == C_IDLE);
  assign out_empty = (state_r != C_OUT);
  assign out_data  = '{digest_word: h_r[255 - 32*idx_r -: 32], word_index: idx_r,
                       last_word: (idx_r == 3'd7)};

  always_comb begin
    s0 = sha256_pkg::ror(w_r[1], 7) ^ sha256_pkg::ror(w_r[1], 18) ^ (w_r[1] >> 3);
    s1 = sha256_pkg::ror(w_r[14], 17) ^ sha256_pkg::ror(w_r[14], 19) ^ (w_r[14] >> 10);
    wn = s1 + w_r[9] + s0 + w_r[0];
    t1 = v_r[7] + (sha256_pkg::ror(v_r[4], 6) ^ sha256_pkg::ror(v_r[4], 11) ^
         sha256_pkg::ror(v_r[4], 25)) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) +
         sha256_pkg::RK[rnd_r] + w_r[0];
    t2 = (sha256_pkg::ror(v_r[0], 2) ^ sha256_pkg::ror(v_r[0], 13) ^
         sha256_pkg::ror(v_r[0], 22)) +
         ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      h_r     <= sha256_pkg::IV;
      rnd_r   <= '0;
      idx_r   <= '0;
    end else begin
      unique case (state_r)
        C_IDLE: begin
          if (blk_valid) begin
            for (int i = 0; i < 16; i++) w_r[i] <= blk_data.block[511 - 32*i -: 32];
            for (int i = 0; i < 8; i++) v_r[i] <= h_r[255 - 32*i -: 32];
            fin_r   <= blk_data.final_blk;
            rnd_r   <= '0;
            state_r <= C_RUN;
          end
        end
        C_RUN: begin
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
          w_r[15] <= wn;
          v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
          v_r[4] <= v_r[3] + t1;
          v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
          v_r[0] <= t1 + t2;
          rnd_r  <= rnd_r + 6'd1;
          if (rnd_r == 6'd63) state_r <= C_SUM;
        end
        C_SUM: begin
          for (int i = 0; i < 8; i++)
            h_r[255 - 32*i -: 32] <= h_r[255 - 32*i -: 32] + v_r[i];
          idx_r   <= '0;
          state_r <= fin_r ? C_OUT : C_IDLE;
        end
        C_OUT: begin
          if (out_pop) begin
            idx_r <= idx_r + 3'd1;
            if (idx_r == 3'd7) begin
              h_r     <= sha256_pkg::IV;
              state_r <= C_IDLE;
            end
          end
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/sha256_stream_hasher_top.sv @@
// SHA-256 stream hasher top level: byte packer front end, compression back end.
// Throughput: one byte beat per cycle while loading and while the packer's block slot is free; each
//   full block passes through the round engine (load, rounds, chain add), overlapped with the next block's load.
// Output: the first digest word follows compression of the final block, which carries the length, and of
//   an extra block when padding spills; eight digest beats then follow.
// Reset: synchronous active-low; chaining value to IV, counters and queues cleared.
module sha256_stream_hasher_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  sha256_pkg::in_beat_t  in_data,
  output logic                  in_full,
  output logic                  out_empty,
  input  logic                  out_pop,
  output sha256_pkg::out_beat_t out_data
);

  logic             blk_valid;
  logic             blk_ready;
  sha256_pkg::blk_t blk_data;

  // Packer holds one finished block in its output register: a one-deep queue
  // so byte loading continues while the core compresses.
  sha256_packer u_packer (
    .clk, .rst_n, .in_push, .in_data, .in_full,
    .blk_valid, .blk_data, .blk_ready
  );

  // Core serialises rounds and holds the digest until all eight beats are popped.
  sha256_core u_core (
    .clk, .rst_n, .blk_valid, .blk_data, .blk_ready,
    .out_empty, .out_pop, .out_data
  );

endmodule
